FILE: sv/brcm_pkg.sv
// Shared types and constants for the banked RAM cartridge mapper.
package brcm_pkg;

  localparam int unsigned MaxBanksDefault = 64;
  localparam int unsigned BankBytes       = 8192;
  localparam int unsigned OffsetW         = 13;
  localparam int unsigned CfgW            = 9;

  localparam logic [7:0]      IoPort      = 8'h8E;
  localparam logic [7:0]      ReadIdle    = 8'hFF;
  localparam logic [7:0]      RamFill     = 8'hFF;
  localparam logic [CfgW-1:0] BankCntRst  = 9'd64;

  typedef enum logic [1:0] {
    OP_MEM_RD = 2'd0,
    OP_MEM_WR = 2'd1,
    OP_IO_RD  = 2'd2,
    OP_IO_WR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ram_write_mode;
  } out_word_t;

endpackage

FILE: sv/banked_ram_cartridge_mapper.sv
// Banked RAM cartridge mapper: bank registers, RAM-write mode, RAM store and sequencer.
//
// A 64 KB CPU window maps onto MAX_BANKS banks of 8 KB through four bank
// registers picked by address bits 14:13 (bit 15 mirrors). Each accepted word
// passes through accept, execute and deliver: reads, RAM writes and I/O
// accesses go from the execute state, where the registered RAM read port is
// addressed, to the done state, which loads the result into the output register
// once it is free or being drained. A bank-select write passes a divide state
// between execute and done: the remainder of the data by the bank count is
// built one quotient bit per cycle on a single shared compare-and-subtract unit.
// After reset the RAM is filled with 0xFF one byte per cycle through all
// MAX_BANKS*8192 bytes (524288 at the default), during which no word is
// accepted; bank_count writes are taken throughout. A finished result sits in
// an output register, so the next word is accepted while it waits to be taken.
module banked_ram_cartridge_mapper #(
  parameter int unsigned MAX_BANKS = brcm_pkg::MaxBanksDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  brcm_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output brcm_pkg::out_word_t       out_word_o,
  input  logic                      cfg_we_i,
  input  logic [brcm_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned Depth = MAX_BANKS * brcm_pkg::BankBytes;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned BankW = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam logic [brcm_pkg::CfgW-1:0] MaxBanksCfg = brcm_pkg::CfgW'(MAX_BANKS);

  brcm_pkg::state_e state_q, state_d;

  brcm_pkg::op_e            op_q;
  logic [15:0]              addr_q;
  logic [7:0]               data_q, data_d;
  logic [7:0]               rem_q, rem_d;
  logic [2:0]               step_q, step_d;
  logic [AddrW-1:0]         clr_q, clr_d;
  logic [brcm_pkg::CfgW-1:0] bank_cnt_q;
  logic [BankW-1:0]         bank_sel_q [4];
  logic                     mode_q, mode_d;
  logic                     out_valid_q;
  brcm_pkg::out_word_t      out_word_q;

  logic                     accept;
  logic                     out_load;
  logic                     bank_we;
  logic [1:0]               win;
  logic [brcm_pkg::CfgW-1:0] n_eff;
  logic [brcm_pkg::CfgW-1:0] shifted;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_addr;
  logic [7:0]               mem_wdata;
  logic [7:0]               rd_q;
  logic [7:0]               mem_q [Depth];

  assign accept = in_valid_i && !in_stall_o;
  assign win    = addr_q[14:13];

  // Zero banks acts as one; more than fitted saturates.
  always_comb begin
    priority if (bank_cnt_q == '0) begin
      n_eff = brcm_pkg::CfgW'(1);
    end else if (bank_cnt_q > MaxBanksCfg) begin
      n_eff = MaxBanksCfg;
    end else begin
      n_eff = bank_cnt_q;
    end
  end

  // Shared restoring-remainder step: one quotient bit per cycle.
  assign shifted = {rem_q, data_q[7]};
  assign rem_d   = (shifted >= n_eff) ? 8'(shifted - n_eff) : shifted[7:0];

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    mem_addr   = AddrW'({bank_sel_q[win], addr_q[brcm_pkg::OffsetW-1:0]});
    mem_wdata  = data_q;
    clr_d      = clr_q;
    mode_d     = mode_q;
    data_d     = data_q;
    step_d     = step_q;
    bank_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      brcm_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = brcm_pkg::RamFill;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = brcm_pkg::ST_IDLE;
        end
      end
      brcm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = brcm_pkg::ST_EXEC;
        end
      end
      brcm_pkg::ST_EXEC: begin
        state_d = brcm_pkg::ST_DONE;
        unique case (op_q)
          brcm_pkg::OP_MEM_RD: ;
          brcm_pkg::OP_MEM_WR: begin
            if (mode_q) begin
              mem_we = 1'b1;
            end else begin
              step_d  = '0;
              state_d = brcm_pkg::ST_DIV;
            end
          end
          brcm_pkg::OP_IO_RD: begin
            if (addr_q[7:0] == brcm_pkg::IoPort) mode_d = 1'b1;
          end
          brcm_pkg::OP_IO_WR: begin
            if (addr_q[7:0] == brcm_pkg::IoPort) mode_d = 1'b0;
          end
          default: ;
        endcase
      end
      brcm_pkg::ST_DIV: begin
        data_d = {data_q[6:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == 3'd7) begin
          bank_we = 1'b1;
          state_d = brcm_pkg::ST_DONE;
        end
      end
      brcm_pkg::ST_DONE: begin
        // Hold until the output register is free or being drained.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = brcm_pkg::ST_IDLE;
        end
      end
      default: state_d = brcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brcm_pkg::ST_CLEAR;
      clr_q       <= '0;
      mode_q      <= 1'b0;
      bank_cnt_q  <= brcm_pkg::BankCntRst;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      for (int i = 0; i < 4; i++) bank_sel_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      mode_q  <= mode_d;
      step_q  <= step_d;
      if (cfg_we_i) bank_cnt_q <= cfg_wdata_i;
      if (bank_we) bank_sel_q[win] <= rem_d[BankW-1:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_word_i.operation;
      addr_q <= in_word_i.address;
      data_q <= in_word_i.write_data;
    end else begin
      data_q <= data_d;
    end
    if (state_q == brcm_pkg::ST_EXEC) begin
      rem_q <= '0;
    end else if (state_q == brcm_pkg::ST_DIV) begin
      rem_q <= rem_d;
    end
    if (out_load) begin
      out_word_q.read_data      <= (op_q == brcm_pkg::OP_MEM_RD) ? rd_q : brcm_pkg::ReadIdle;
      out_word_q.ram_write_mode <= mode_q;
    end
  end

  // Single-port RAM, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rd_q <= mem_q[mem_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == brcm_pkg::ST_EXEC)
    else $error("accepted word did not enter execute");

  a_ram_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == brcm_pkg::ST_CLEAR) ||
               (op_q == brcm_pkg::OP_MEM_WR && mode_q))
    else $error("RAM written outside fill or RAM-write mode");

  a_bank_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(bank_sel_q[0]) < MAX_BANKS) && (32'(bank_sel_q[1]) < MAX_BANKS) &&
    (32'(bank_sel_q[2]) < MAX_BANKS) && (32'(bank_sel_q[3]) < MAX_BANKS))
    else $error("bank register beyond fitted banks");

  a_done_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brcm_pkg::ST_DONE && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("finished word not loaded into output register");

endmodule

FILE: tb/tb.sv
// Testbench for the banked RAM cartridge mapper: shadow model, scoreboard and bus drivers.
module tb;
  import brcm_pkg::*;

  localparam int unsigned MaxBanks   = MaxBanksDefault;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainPause = 16;

  // Shadow of the mapper: bank registers, write mode, RAM image and the replies still owed.
  class mapper_shadow;
    logic [CfgW-1:0] bank_count;
    logic [7:0]      bank_sel [4];
    logic            ram_mode;
    logic [7:0]      ram_img [int];
    out_word_t       replies [$];
    int              errors;
    int              checked;

    function new();
      bank_count = BankCntRst;
      foreach (bank_sel[i]) bank_sel[i] = '0;
      ram_mode = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // Apply one accepted bus access and queue the reply it owes.
    function void apply_access(in_word_t w);
      int unsigned banks;
      int unsigned idx;
      logic [1:0]  win;
      out_word_t   r;
      win   = w.address[14:13];
      idx   = (int'(bank_sel[win]) % MaxBanks) * BankBytes + int'(w.address[12:0]);
      banks = 32'(bank_count);
      if (banks == 0) banks = 1;
      if (banks > MaxBanks) banks = MaxBanks;
      r.read_data = ReadIdle;
      case (w.operation)
        OP_MEM_RD: begin
          r.read_data = ram_img.exists(idx) ? ram_img[idx] : RamFill;
        end
        OP_MEM_WR: begin
          if (ram_mode) ram_img[idx] = w.write_data;
          else bank_sel[win] = 8'(int'(w.write_data) % banks);
        end
        OP_IO_RD: begin
          if (w.address[7:0] == IoPort) ram_mode = 1'b1;
        end
        default: begin
          if (w.address[7:0] == IoPort) ram_mode = 1'b0;
        end
      endcase
      r.ram_write_mode = ram_mode;
      replies.push_back(r);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (replies.size() == 0) begin
        $error("result word with nothing expected: read_data %h ram_write_mode %b",
               got.read_data, got.ram_write_mode);
        errors++;
        return;
      end
      want = replies.pop_front();
      checked++;
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.ram_write_mode !== want.ram_write_mode) begin
        $error("ram_write_mode: expected %b, got %b", want.ram_write_mode, got.ram_write_mode);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  in_word_t        in_word_i;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_word_t       out_word_o;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  mapper_shadow    shadow;
  int unsigned     cycles = 0;
  int              accesses;
  int              counted;
  int              settings;
  int              burst_left;
  int              stall_left = 0;
  int              stall_mode = 0;
  logic [12:0]     hot_offsets [8];
  logic [CfgW-1:0] count_plan [10];

  banked_ram_cartridge_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, shadow.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall pattern: free, sparse random, periodic, or heavy, switching every so often.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ((cycles % 7) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) shadow.check_reply(out_word_o);
  end

  // Drop valid for a random gap once the current burst is used up.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Hold the word until it is taken.
  task automatic send_access(input in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.apply_access(w);
    accesses++;
    if (!((w.operation == OP_IO_RD || w.operation == OP_IO_WR) && w.address[7:0] != IoPort))
      counted++;
  endtask

  task automatic access(input op_e op, input logic [15:0] addr, input logic [7:0] data);
    in_word_t w;
    w.operation  = op;
    w.address    = addr;
    w.write_data = data;
    pace();
    send_access(w);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  task automatic set_bank_count(input logic [CfgW-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.bank_count = v;
    settings++;
  endtask

  function automatic logic [15:0] pick_addr();
    logic [12:0] off;
    if ($urandom_range(0, 9) < 7) off = hot_offsets[$urandom_range(0, 7)];
    else off = 13'($urandom);
    return {1'($urandom), 2'($urandom), off};
  endfunction

  function automatic logic [15:0] port_addr();
    logic [7:0] port;
    port = ($urandom_range(0, 1) == 0) ? IoPort : 8'($urandom);
    return {8'($urandom), port};
  endfunction

  // One random bus sequence: RAM fill, bank selects, read-back, or noise.
  task automatic random_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    n    = $urandom_range(1, 8);
    if (kind < 35) begin
      access(OP_IO_RD, {8'($urandom), IoPort}, 8'($urandom));
      repeat (n) access(OP_MEM_WR, pick_addr(), 8'($urandom));
      if ($urandom_range(0, 3) != 0) access(OP_IO_WR, {8'($urandom), IoPort}, 8'($urandom));
    end else if (kind < 60) begin
      access(OP_IO_WR, {8'($urandom), IoPort}, 8'($urandom));
      repeat ((n + 1) / 2) access(OP_MEM_WR, pick_addr(), 8'($urandom));
    end else if (kind < 90) begin
      repeat (n) access(OP_MEM_RD, pick_addr(), 8'($urandom));
    end else begin
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          access(op_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        else
          access(op_e'($urandom_range(2, 3)), port_addr(), 8'($urandom));
      end
    end
  endtask

  initial begin
    int target;
    shadow      = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    accesses    = 0;
    counted     = 0;
    settings    = 0;
    burst_left  = 0;
    hot_offsets[0] = 13'h0000;
    hot_offsets[1] = 13'h1FFF;
    for (int i = 2; i < 8; i++) hot_offsets[i] = 13'($urandom);
    count_plan = '{9'd256, 9'd3, 9'd65, 9'd63, 9'd0, 9'd1, 9'd511, 9'd64, 9'd0, 9'd0};
    count_plan[8] = 9'($urandom_range(1, 511));
    count_plan[9] = 9'($urandom_range(1, 64));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // taken while the RAM clear runs
    set_bank_count(9'd64);

    // fresh RAM, mirror and upper address bits on the port
    access(OP_MEM_RD, 16'h0000, 8'h00);
    access(OP_MEM_RD, 16'hFFFF, 8'hFF);
    access(OP_IO_RD,  {8'hFF, IoPort}, 8'h00);
    access(OP_MEM_WR, 16'h0000, 8'h00);
    access(OP_MEM_WR, 16'hFFFF, 8'hA5);
    access(OP_MEM_RD, 16'h8000, 8'h00);
    access(OP_MEM_RD, 16'h7FFF, 8'h00);
    // other ports leave the mode alone; a port write with other upper bits clears it
    access(OP_IO_RD,  16'h008F, 8'h00);
    access(OP_IO_WR,  16'hFF00, 8'hFF);
    access(OP_IO_WR,  {8'h01, IoPort}, 8'h00);
    // bank selects, data folded by the bank count, then a RAM write through a bank
    access(OP_MEM_WR, 16'h2000, 8'hFF);
    access(OP_MEM_WR, 16'hE000, 8'h41);
    access(OP_MEM_RD, 16'h2000, 8'h00);
    access(OP_IO_RD,  {8'h00, IoPort}, 8'hFF);
    access(OP_MEM_WR, 16'h3FFF, 8'h5A);
    access(OP_MEM_RD, 16'hBFFF, 8'h00);
    access(OP_IO_WR,  {8'h00, IoPort}, 8'h00);

    // zero banks acts as one
    wait_drained();
    set_bank_count(9'd0);
    access(OP_MEM_WR, 16'h4000, 8'hC3);
    access(OP_MEM_RD, 16'h4000, 8'h00);
    // above the maximum saturates
    wait_drained();
    set_bank_count(9'd511);
    access(OP_MEM_WR, 16'h6000, 8'h80);
    access(OP_MEM_WR, 16'h6000, 8'h7F);
    // shrink the count: bank registers beyond it still map
    wait_drained();
    set_bank_count(9'd1);
    access(OP_MEM_RD, 16'h3FFF, 8'h00);
    access(OP_MEM_WR, 16'h2000, 8'h33);
    access(OP_MEM_RD, 16'h2000, 8'h00);

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      set_bank_count(count_plan[p]);
      target = counted + 172;
      while (counted < target) random_sequence();
    end

    wait_drained();
    $display("%0d bus accesses under %0d bank-count settings, %0d result words checked",
             accesses, settings, shadow.checked);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d words never arrived", shadow.errors, shadow.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/brcm_pkg.sv
sv/banked_ram_cartridge_mapper.sv
tb/tb.sv
